@@ hdl/fixed_point_alu_unit_macros.svh @@
// assertion helpers
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpa check failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpa check failed");

`endif

@@ hdl/fpa_pkg.sv @@
package fpa_pkg;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0,
		OP_SUB = 5'd1,
		OP_MUL = 5'd2,
		OP_DIV = 5'd3,
		OP_NEG = 5'd4,
		OP_INC = 5'd5,
		OP_DEC = 5'd6,
		OP_GT  = 5'd7,
		OP_LT  = 5'd8,
		OP_GE  = 5'd9,
		OP_LE  = 5'd10,
		OP_EQ  = 5'd11,
		OP_NE  = 5'd12,
		OP_MIN = 5'd13,
		OP_MAX = 5'd14,
		OP_I2F = 5'd15,
		OP_F2I = 5'd16
	} fpa_op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic [31:0] SMAX = 32'h7fff_ffff;
	localparam logic [31:0] SMIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] res;
		logic        cmp;
		logic [1:0]  status;
		logic        is_mul;
		logic        is_div;
		logic        div_zero;
		logic        div_neg;
		logic        div_ovf;
	} fpa_side_t;

	// {overflow, clamped value}
	function automatic logic [32:0] sat33(input logic [32:0] v);
		logic [32:0] r;
		if (v[32] != v[31]) begin
			r = {1'b1, (v[32] ? SMIN : SMAX)};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction
endpackage

@@ hdl/fpa_req_if.sv @@
interface fpa_req_if;
	logic               valid;
	logic               ready;
	logic [4:0]         opcode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

@@ hdl/fpa_rsp_if.sv @@
interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic               compare_true;
	logic [1:0]         status;

	modport source (output valid, result, compare_true, status, input ready);
	modport sink (input valid, result, compare_true, status, output ready);
endinterface

@@ hdl/fpa_front.sv @@
module fpa_front #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [4:0]                opcode,
	input  logic signed [31:0]        operand_a,
	input  logic signed [31:0]        operand_b,
	output logic                      v_s2,
	output fpa_pkg::fpa_side_t        side_s2,
	output logic [FRAC_BITS+32:0]     rem_s2,
	output logic [32:0]               den_s2
);
	import fpa_pkg::*;

	localparam int NW = FRAC_BITS + 33;

	fpa_op_t                op;
	logic [32:0]            a_x, b_x, sat_v;
	logic [32:0]            sum_sat, dif_sat, neg_sat, inc_sat, dec_sat;
	logic [FRAC_BITS+32:0]  i2f_sh;
	logic                   i2f_ovf;
	logic [31:0]            mag_a, mag_b;
	logic [NW-1:0]          num_c;
	fpa_side_t              side_c;

	logic                   v_s1;
	fpa_side_t              side_s1;
	logic signed [63:0]     prod_s1;
	logic [NW-1:0]          num_s1;
	logic [32:0]            den_s1;

	logic [63:0]            m_mag, m_rnd;
	logic                   m_neg, m_ovf;
	logic [FRAC_BITS:0]     n_hi;
	fpa_side_t              side_m;

	always_comb begin
		op      = fpa_op_t'(opcode);
		a_x     = {operand_a[31], operand_a};
		b_x     = {operand_b[31], operand_b};
		sum_sat = sat33(a_x + b_x);
		dif_sat = sat33(a_x - b_x);
		neg_sat = sat33(33'd0 - a_x);
		inc_sat = sat33(a_x + 33'd1);
		dec_sat = sat33(a_x - 33'd1);
		i2f_sh  = {{(FRAC_BITS + 1){operand_a[31]}}, operand_a} << FRAC_BITS;
		i2f_ovf = !((i2f_sh[FRAC_BITS+32:31] == '0) || (i2f_sh[FRAC_BITS+32:31] == '1));
		mag_a   = operand_a[31] ? (32'd0 - operand_a) : operand_a;
		mag_b   = operand_b[31] ? (32'd0 - operand_b) : operand_b;
		num_c   = NW'({mag_a, {FRAC_BITS{1'b0}}, 1'b0}) + NW'(mag_b);
		sat_v   = '0;

		side_c          = '0;
		side_c.div_zero = (operand_b == 32'sd0);
		side_c.div_neg  = operand_a[31] ^ operand_b[31];
		case (op)
			OP_ADD: sat_v = sum_sat;
			OP_SUB: sat_v = dif_sat;
			OP_NEG: sat_v = neg_sat;
			OP_INC: sat_v = inc_sat;
			OP_DEC: sat_v = dec_sat;
			default: sat_v = '0;
		endcase
		case (op)
			OP_ADD, OP_SUB, OP_NEG, OP_INC, OP_DEC: begin
				side_c.res    = sat_v[31:0];
				side_c.status = sat_v[32] ? ST_OVF : ST_OK;
			end
			OP_MUL: side_c.is_mul = 1'b1;
			OP_DIV: side_c.is_div = 1'b1;
			OP_GT:  side_c.cmp = operand_a > operand_b;
			OP_LT:  side_c.cmp = operand_a < operand_b;
			OP_GE:  side_c.cmp = operand_a >= operand_b;
			OP_LE:  side_c.cmp = operand_a <= operand_b;
			OP_EQ:  side_c.cmp = operand_a == operand_b;
			OP_NE:  side_c.cmp = operand_a != operand_b;
			OP_MIN: side_c.res = (operand_a < operand_b) ? operand_a : operand_b;
			OP_MAX: side_c.res = (operand_a > operand_b) ? operand_a : operand_b;
			OP_I2F: begin
				if (i2f_ovf) begin
					side_c.res    = operand_a[31] ? SMIN : SMAX;
					side_c.status = ST_OVF;
				end else begin
					side_c.res = i2f_sh[31:0];
				end
			end
			OP_F2I: side_c.res = 32'(operand_a >>> FRAC_BITS);
			default: side_c.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			prod_s1 <= operand_a * operand_b;
			num_s1  <= num_c;
			den_s1  <= {mag_b, 1'b0};
		end
	end

	// rounding of the product, overflow precheck of the quotient
	always_comb begin
		m_neg  = prod_s1[63];
		m_mag  = m_neg ? (64'd0 - prod_s1) : prod_s1;
		m_rnd  = (m_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		m_ovf  = m_neg ? (m_rnd > 64'h8000_0000) : (m_rnd > 64'h7fff_ffff);
		n_hi   = num_s1[NW-1:32];
		side_m = side_s1;
		side_m.div_ovf = (33'(n_hi) >= den_s1);
		if (side_s1.is_mul) begin
			side_m.is_mul = 1'b0;
			if (m_ovf) begin
				side_m.res    = m_neg ? SMIN : SMAX;
				side_m.status = ST_OVF;
			end else begin
				side_m.res = m_neg ? (32'd0 - m_rnd[31:0]) : m_rnd[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_m;
			rem_s2  <= num_s1;
			den_s2  <= den_s1;
		end
	end
endmodule

@@ hdl/fpa_div_step.sv @@
module fpa_div_step #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
	parameter int K         = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  fpa_pkg::fpa_side_t    side_in,
	input  logic [FRAC_BITS+32:0] rem_in,
	input  logic [32:0]           den_in,
	input  logic [31:0]           quo_in,
	output logic                  v_q,
	output fpa_pkg::fpa_side_t    side_q,
	output logic [FRAC_BITS+32:0] rem_q,
	output logic [32:0]           den_q,
	output logic [31:0]           quo_q
);
	import fpa_pkg::*;

	localparam int NW = FRAC_BITS + 33;

	logic [NW-1:0] hi, den_w;
	logic          take;
	logic [31:0]   quo_nx;

	always_comb begin
		den_w  = NW'(den_in);
		hi     = rem_in >> K;
		take   = (hi >= den_w);
		quo_nx = quo_in;
		quo_nx[K] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			rem_q  <= take ? (rem_in - (den_w << K)) : rem_in;
			den_q  <= den_in;
			quo_q  <= quo_nx;
		end
	end
endmodule

@@ hdl/fixed_point_alu_unit.sv @@
// channel | role | payload
// req     | sink | opcode, operand_a, operand_b
// rsp     | src  | result, compare_true, status
//
// One item per cycle while rsp is not stalled; each item passes s1, s2, the divider steps and the output register.
// Depth is set by the restoring divider, one quotient bit per stage.
// arst_n clears all valid bits; data registers are not reset.
// A stalled rsp freezes the whole pipeline; req.ready follows.
module fixed_point_alu_unit #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	localparam int NW = FRAC_BITS + 33;
	localparam int QB = 32;

	logic              en;
	logic              v_c    [0:QB];
	fpa_side_t         side_c [0:QB];
	logic [NW-1:0]     rem_c  [0:QB-1];
	logic [32:0]       den_c  [0:QB-1];
	logic [31:0]       quo_c  [0:QB];

	logic              out_v_q;
	logic [31:0]       result_q;
	logic              cmp_q;
	logic [1:0]        status_q;

	fpa_side_t         fin;
	logic [31:0]       fin_res;
	logic [1:0]        fin_st;
	logic              d_ovf;

	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;
	assign quo_c[0]  = '0;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.opcode    (req.opcode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.v_s2      (v_c[0]),
		.side_s2   (side_c[0]),
		.rem_s2    (rem_c[0]),
		.den_s2    (den_c[0])
	);

	for (genvar i = 0; i < QB; i++) begin : g_div
		if (i < QB - 1) begin : g_mid
			fpa_div_step #(.FRAC_BITS(FRAC_BITS), .K(QB - 1 - i)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.v_in    (v_c[i]),
				.side_in (side_c[i]),
				.rem_in  (rem_c[i]),
				.den_in  (den_c[i]),
				.quo_in  (quo_c[i]),
				.v_q     (v_c[i+1]),
				.side_q  (side_c[i+1]),
				.rem_q   (rem_c[i+1]),
				.den_q   (den_c[i+1]),
				.quo_q   (quo_c[i+1])
			);
		end else begin : g_last
			fpa_div_step #(.FRAC_BITS(FRAC_BITS), .K(QB - 1 - i)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.v_in    (v_c[i]),
				.side_in (side_c[i]),
				.rem_in  (rem_c[i]),
				.den_in  (den_c[i]),
				.quo_in  (quo_c[i]),
				.v_q     (v_c[i+1]),
				.side_q  (side_c[i+1]),
				.rem_q   (),
				.den_q   (),
				.quo_q   (quo_c[i+1])
			);
		end
	end

	always_comb begin
		fin     = side_c[QB];
		fin_res = fin.res;
		fin_st  = fin.status;
		d_ovf   = fin.div_ovf
			|| (fin.div_neg ? (quo_c[QB] > 32'h8000_0000) : quo_c[QB][31]);
		if (fin.is_div) begin
			if (fin.div_zero) begin
				fin_res = '0;
				fin_st  = ST_DIVZ;
			end else if (d_ovf) begin
				fin_res = fin.div_neg ? SMIN : SMAX;
				fin_st  = ST_OVF;
			end else begin
				fin_res = fin.div_neg ? (32'd0 - quo_c[QB]) : quo_c[QB];
				fin_st  = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= fin_res;
			cmp_q    <= fin.cmp;
			status_q <= fin_st;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.result       = result_q;
	assign rsp.compare_true = cmp_q;
	assign rsp.status       = status_q;
endmodule

@@ hdl/fpa_checker.sv @@
`include "fixed_point_alu_unit_macros.svh"

module fpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_result,
	input logic        rsp_cmp,
	input logic [1:0]  rsp_status
);
	import fpa_pkg::*;

	`FPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result))
	`FPA_ASSERT_NOW(a_divz_zero, rsp_valid && rsp_status == ST_DIVZ, rsp_result == '0 && !rsp_cmp)
	`FPA_ASSERT_NOW(a_cmp_clean, rsp_valid && rsp_cmp, rsp_result == '0 && rsp_status == ST_OK)
	`FPA_ASSERT_NOW(a_ovf_clamp, rsp_valid && rsp_status == ST_OVF, rsp_result == SMAX || rsp_result == SMIN)
endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.result),
	.rsp_cmp    (rsp.compare_true),
	.rsp_status (rsp.status)
);
